// ===== design/rcf_pkg.sv =====
// Shared types, constants and pipeline schedule for the regularized Coulomb friction block.
// No dependencies; every other design file but rcf_ifs refers to it by scoped names.
package rcf_pkg;

    // Configuration register indexes
    typedef enum logic [7:0] {
        CFG_FRICTION_ENABLE = 8'd0,
        CFG_MU_STICK        = 8'd1,
        CFG_MU_SLIDE        = 8'd2,
        CFG_TIME_STEP       = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        friction_enable;
        logic [17:0] mu_stick;
        logic [17:0] mu_slide;
        logic [31:0] time_step;
    } t_cfg;

    localparam logic [31:0] TIME_STEP_RST = 32'd4294967;

    localparam logic [63:0] POS_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_CAP = 64'h8000_0000_0000_0000;

    // Speed limits in Q.16 and scale factors
    localparam logic [23:0] V_DECAY_MAX = 24'd10485760;   // 160.0
    localparam logic [20:0] VC_MAX      = 21'h10_0000;    // 16.0
    localparam logic [28:0] X_SCALE     = 29'd429496730;  // 0.1 in Q0.32
    localparam logic [56:0] SQ_BIAS     = 57'd28147497671; // 0.01^2 in Q.48
    localparam logic [32:0] ONE_Q32     = 33'h1_0000_0000;

    // exp(-2^k) in Q0.32, k = -16 .. 3
    localparam int EXP_TERMS = 20;
    localparam logic [31:0] EXP_TAB [EXP_TERMS] = '{
        32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
        32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
        32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
        32'd4034748382, 32'd3790295335, 32'd3344923893, 32'd2605029347,
        32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
    };

    // Pipeline schedule: register index at which each operation lands
    localparam int K_PP       = 1;
    localparam int K_SUM      = 2;
    localparam int K_SAT      = 3;
    localparam int DIV1_FIRST = 2;
    localparam int DIV1_BITS  = 24;
    localparam int K_V        = DIV1_FIRST + DIV1_BITS;
    localparam int K_SQI      = K_V + 1;
    localparam int EXP_FIRST  = K_SQI + 1;
    localparam int SQ_FIRST   = K_SQI + 1;
    localparam int SQ_STEPS   = 29;
    localparam int SQ_TOP     = 2 * (SQ_STEPS - 1);
    localparam int K_QI       = SQ_FIRST + SQ_STEPS;
    localparam int DIV2_FIRST = K_QI + 1;
    localparam int DIV2_BITS  = 33;
    localparam int K_R        = DIV2_FIRST + DIV2_BITS;
    localparam int K_BASE     = K_R + 1;
    localparam int K_MUP      = K_BASE + 1;
    localparam int K_MU       = K_MUP + 1;
    localparam int K_LP       = K_MU + 1;
    localparam int K_LS       = K_LP + 1;
    localparam int K_LIM      = K_LS + 1;
    localparam int K_OUT      = K_LIM + 1;
    localparam int NST        = K_OUT + 1;

    typedef struct packed {
        logic        nneg;
        logic        tneg;
        logic [31:0] nmag;
        logic [31:0] tmag;
        logic [47:0] pn;
        logic [47:0] pt;
        logic [63:0] pn_lo;
        logic [47:0] pn_hi;
        logic [63:0] pt_lo;
        logic [47:0] pt_hi;
        logic [79:0] fn_sum;
        logic [79:0] ft_sum;
        logic [63:0] fn_mag;
        logic [63:0] ft_mag;
        logic [63:0] fn;
        logic [63:0] ft;
        logic        d_over;
        logic [32:0] d_rem;
        logic [23:0] d_quot;
        logic        vbig;
        logic [52:0] xprod;
        logic [20:0] vc;
        logic [41:0] sq;
        logic [32:0] e_acc;
        logic [56:0] s_n;
        logic [57:0] s_res;
        logic        q_over;
        logic [29:0] q_rem;
        logic [32:0] q_quot;
        logic [32:0] r;
        logic        dsgn;
        logic [50:0] dprod;
        logic [17:0] base;
        logic [50:0] muprod;
        logic [17:0] mu;
        logic [49:0] l_lo;
        logic [49:0] l_hi;
        logic [81:0] l_sum;
        logic [62:0] limit;
        logic        slip;
    } t_pipe;

endpackage

// ===== design/rcf_ifs.sv =====
// Handshake channels of the friction block: contact points in, forces out, register writes.
// Depends on nothing; payload widths follow the field list of the block.
interface rcf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] gap_normal;
    logic signed [31:0] gap_tangent;
    logic        [47:0] penalty_normal;
    logic        [47:0] penalty_tangent;

    modport source (output valid, gap_normal, gap_tangent, penalty_normal, penalty_tangent,
                    input ready);
    modport sink   (input valid, gap_normal, gap_tangent, penalty_normal, penalty_tangent,
                    output ready);
endinterface

interface rcf_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] normal_force;
    logic signed [63:0] tangent_force;
    logic        [17:0] friction_coeff;
    logic               slip;

    modport source (output valid, normal_force, tangent_force, friction_coeff, slip,
                    input ready);
    modport sink   (input valid, normal_force, tangent_force, friction_coeff, slip,
                    output ready);
endinterface

interface rcf_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/rcf_cfg.sv =====
// Configuration register file of the friction block.
// Depends on rcf_pkg and the rcf_cfg_if channel.
module rcf_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rcf_cfg_if.sink       i_cfg,
    output rcf_pkg::t_cfg o_cfg
);

    rcf_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.friction_enable <= 1'b0;
            r_cfg.mu_stick        <= '0;
            r_cfg.mu_slide        <= '0;
            r_cfg.time_step       <= rcf_pkg::TIME_STEP_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                rcf_pkg::CFG_FRICTION_ENABLE: r_cfg.friction_enable <= i_cfg.data[0];
                rcf_pkg::CFG_MU_STICK:        r_cfg.mu_stick        <= i_cfg.data[17:0];
                rcf_pkg::CFG_MU_SLIDE:        r_cfg.mu_slide        <= i_cfg.data[17:0];
                rcf_pkg::CFG_TIME_STEP:       r_cfg.time_step       <= i_cfg.data;
                default: ; // unknown index: drop the request
            endcase
        end
    end

endmodule

// ===== design/regularized_coulomb_friction.sv =====
// rcf_pkg::NST (99) register stages, taking one contact point per cycle unless the result
// side holds back ready and no stage is empty.
// The long paths are the 24-step speed divider, the 29-step square root and the 33-step
// regularizer divider, each one bit per register stage, with the exp product chain alongside.
// Each stage loads whenever its slot is empty or drains, so bubbles fill while a result waits.
// Synchronous active-low reset empties the pipeline and restores the register defaults.
module regularized_coulomb_friction (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rcf_in_if.sink    i_in,
    rcf_out_if.source o_out,
    rcf_cfg_if.sink   i_cfg
);

    localparam int NST = rcf_pkg::NST;

    rcf_pkg::t_cfg  cfg;
    rcf_pkg::t_pipe r_pipe [NST];
    rcf_pkg::t_pipe n_pipe [NST];
    logic [NST-1:0] r_v;
    logic [NST-1:0] vin;
    logic [NST:0]   rdy;

    rcf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    function automatic rcf_pkg::t_pipe f_entry(input logic [31:0] gn, input logic [31:0] gt,
                                               input logic [47:0] pn, input logic [47:0] pt);
        rcf_pkg::t_pipe p;
        p      = '0;
        p.nneg = gn[31];
        p.tneg = gt[31];
        p.nmag = gn[31] ? (~gn + 32'd1) : gn;
        p.tmag = gt[31] ? (~gt + 32'd1) : gt;
        p.pn   = pn;
        p.pt   = pt;
        return p;
    endfunction

    function automatic rcf_pkg::t_pipe f_stage(input int k, input rcf_pkg::t_pipe p,
                                               input rcf_pkg::t_cfg c);
        rcf_pkg::t_pipe o;
        logic [32:0] dt;
        logic [32:0] rem2;
        logic [29:0] qrem2;
        logic [29:0] qdiv;
        logic [27:0] vc7;
        logic [63:0] m;
        logic [63:0] cap;
        logic [64:0] eprod;
        logic [57:0] sbit;
        logic [57:0] st;
        logic [17:0] dmag;
        int j;
        o  = p;
        dt = (c.time_step == '0) ? 33'd1 : {1'b0, c.time_step};
        if (k == rcf_pkg::K_PP) begin
            o.pn_lo  = p.nmag * p.pn[31:0];
            o.pn_hi  = p.nmag * p.pn[47:32];
            o.pt_lo  = p.tmag * p.pt[31:0];
            o.pt_hi  = p.tmag * p.pt[47:32];
            o.d_over = {p.tmag, 8'b0} >= 40'(dt);
            o.d_rem  = 33'({p.tmag, 8'b0});
            o.d_quot = '0;
        end
        if (k == rcf_pkg::K_SUM) begin
            o.fn_sum = {16'b0, p.pn_lo} + {p.pn_hi, 32'b0};
            o.ft_sum = {16'b0, p.pt_lo} + {p.pt_hi, 32'b0};
        end
        if (k == rcf_pkg::K_SAT) begin
            cap      = p.nneg ? rcf_pkg::NEG_CAP : rcf_pkg::POS_CAP;
            m        = (p.fn_sum[79:16] > cap) ? cap : p.fn_sum[79:16];
            o.fn_mag = m;
            o.fn     = p.nneg ? (~m + 64'd1) : m;
            cap      = p.tneg ? rcf_pkg::NEG_CAP : rcf_pkg::POS_CAP;
            m        = (p.ft_sum[79:16] > cap) ? cap : p.ft_sum[79:16];
            o.ft_mag = m;
            o.ft     = p.tneg ? (~m + 64'd1) : m;
        end
        // speed: one quotient bit a stage, remainder kept below the time step
        if (k >= rcf_pkg::DIV1_FIRST && k < rcf_pkg::DIV1_FIRST + rcf_pkg::DIV1_BITS) begin
            rem2 = {p.d_rem[31:0], 1'b0};
            if (rem2 >= dt) begin
                o.d_rem  = rem2 - dt;
                o.d_quot = {p.d_quot[22:0], 1'b1};
            end else begin
                o.d_rem  = rem2;
                o.d_quot = {p.d_quot[22:0], 1'b0};
            end
        end
        if (k == rcf_pkg::K_V) begin
            o.vbig  = p.d_over || (p.d_quot >= rcf_pkg::V_DECAY_MAX);
            o.xprod = p.d_quot * rcf_pkg::X_SCALE;
            o.vc    = (p.d_over || (p.d_quot > 24'(rcf_pkg::VC_MAX))) ? rcf_pkg::VC_MAX
                                                                    : p.d_quot[20:0];
            o.sq    = 42'(o.vc) * 42'(o.vc);
        end
        if (k == rcf_pkg::K_SQI) begin
            o.s_n   = 57'({p.sq, 16'b0}) + rcf_pkg::SQ_BIAS;
            o.s_res = '0;
            o.e_acc = p.vbig ? 33'd0 : rcf_pkg::ONE_Q32;
        end
        // exp(-x): multiply in one table entry per set bit of x
        if (k >= rcf_pkg::EXP_FIRST && k < rcf_pkg::EXP_FIRST + rcf_pkg::EXP_TERMS) begin
            j = k - rcf_pkg::EXP_FIRST;
            if (p.xprod[32 + j]) begin
                eprod   = 65'(p.e_acc) * 65'(rcf_pkg::EXP_TAB[j]);
                o.e_acc = eprod[64:32];
            end
        end
        // integer square root, one result bit a stage
        if (k >= rcf_pkg::SQ_FIRST && k < rcf_pkg::SQ_FIRST + rcf_pkg::SQ_STEPS) begin
            j    = k - rcf_pkg::SQ_FIRST;
            sbit = 58'(1) << (rcf_pkg::SQ_TOP - 2 * j);
            st   = p.s_res + sbit;
            if ({1'b0, p.s_n} >= st) begin
                o.s_n   = 57'({1'b0, p.s_n} - st);
                o.s_res = (p.s_res >> 1) + sbit;
            end else begin
                o.s_res = p.s_res >> 1;
            end
        end
        if (k == rcf_pkg::K_QI) begin
            vc7      = {p.vc, 7'b0};
            qdiv     = {1'b0, p.s_res[28:0]};
            o.q_over = 30'(vc7) >= qdiv;
            o.q_rem  = 30'(vc7);
            o.q_quot = '0;
        end
        if (k >= rcf_pkg::DIV2_FIRST && k < rcf_pkg::DIV2_FIRST + rcf_pkg::DIV2_BITS) begin
            qdiv  = {1'b0, p.s_res[28:0]};
            qrem2 = {p.q_rem[28:0], 1'b0};
            if (qrem2 >= qdiv) begin
                o.q_rem  = qrem2 - qdiv;
                o.q_quot = {p.q_quot[31:0], 1'b1};
            end else begin
                o.q_rem  = qrem2;
                o.q_quot = {p.q_quot[31:0], 1'b0};
            end
        end
        if (k == rcf_pkg::K_R) begin
            o.r     = (p.q_over || (p.q_quot > rcf_pkg::ONE_Q32)) ? rcf_pkg::ONE_Q32 : p.q_quot;
            o.dsgn  = c.mu_stick >= c.mu_slide;
            dmag    = o.dsgn ? (c.mu_stick - c.mu_slide) : (c.mu_slide - c.mu_stick);
            o.dprod = dmag * p.e_acc;
        end
        if (k == rcf_pkg::K_BASE) begin
            o.base = p.dsgn ? (c.mu_slide + p.dprod[49:32]) : (c.mu_slide - p.dprod[49:32]);
        end
        if (k == rcf_pkg::K_MUP) begin
            o.muprod = p.base * p.r;
        end
        if (k == rcf_pkg::K_MU) begin
            o.mu = c.friction_enable ? p.muprod[49:32] : 18'd0;
        end
        if (k == rcf_pkg::K_LP) begin
            o.l_lo = p.mu * p.fn_mag[31:0];
            o.l_hi = p.mu * p.fn_mag[63:32];
        end
        if (k == rcf_pkg::K_LS) begin
            o.l_sum = {32'b0, p.l_lo} + {p.l_hi, 32'b0};
        end
        if (k == rcf_pkg::K_LIM) begin
            o.limit = (p.l_sum[81:16] > 66'(rcf_pkg::POS_CAP)) ? rcf_pkg::POS_CAP[62:0]
                                                               : p.l_sum[78:16];
        end
        if (k == rcf_pkg::K_OUT) begin
            o.slip = p.ft_mag > {1'b0, p.limit};
            if (o.slip) begin
                o.ft = {1'b0, p.limit};
            end
        end
        return o;
    endfunction

    // a stage may load when it is empty or its content moves on
    always_comb begin
        rdy[NST] = o_out.ready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k + 1];
        end
    end

    assign vin = {r_v[NST-2:0], i_in.valid};

    always_comb begin
        n_pipe[0] = f_entry(i_in.gap_normal, i_in.gap_tangent,
                            i_in.penalty_normal, i_in.penalty_tangent);
        for (int k = 1; k < NST; k++) begin
            n_pipe[k] = f_stage(k, r_pipe[k - 1], cfg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= vin[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (rdy[k]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    assign i_in.ready           = rdy[0];
    assign o_out.valid          = r_v[NST-1];
    assign o_out.normal_force   = $signed(r_pipe[NST-1].fn);
    assign o_out.tangent_force  = $signed(r_pipe[NST-1].ft);
    assign o_out.friction_coeff = r_pipe[NST-1].mu;
    assign o_out.slip           = r_pipe[NST-1].slip;

    a_mu_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST-1] && !cfg.friction_enable) |-> (r_pipe[NST-1].mu == 18'd0))
        else $error("friction coefficient nonzero with friction disabled");

    a_slip_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST-1] && r_pipe[NST-1].slip) |-> !r_pipe[NST-1].ft[63])
        else $error("slipping tangent force is negative");

    a_stick_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST-1] && !r_pipe[NST-1].slip) |->
            (r_pipe[NST-1].ft_mag <= {1'b0, r_pipe[NST-1].limit}))
        else $error("sticking force exceeds the Coulomb limit");

    a_mu_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NST-1] |-> ((r_pipe[NST-1].mu <= cfg.mu_stick) ||
                        (r_pipe[NST-1].mu <= cfg.mu_slide)))
        else $error("friction coefficient above both coefficients");

    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v[0])
        else $error("accepted request not held in the first stage");

endmodule

// ===== tb/sv/rcf_checker.sv =====
// Result checker for the friction block: watches the request, result and register channels.
// Depends on rcf_pkg and the channel interfaces; predicts each result and compares it.
module rcf_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    rcf_in_if    i_in,
    rcf_out_if   i_out,
    rcf_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_pending,
    output int   o_results,
    output int   o_slips
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [63:0] normal_force;
        logic signed [63:0] tangent_force;
        logic        [17:0] friction_coeff;
        logic               slip;
    } t_contact_res;

    t_contact_res forces_due[$];

    logic        en_q;
    logic [17:0] mus_q;
    logic [17:0] mud_q;
    logic [31:0] dt_q;

    assign o_pending = forces_due.size();

    // floor(a*b / 2^16), clipped to cap
    function automatic logic [63:0] mul_q16_sat(logic [63:0] a, logic [63:0] b,
                                                logic [63:0] cap);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> 16;
        return (p > {64'd0, cap}) ? cap : p[63:0];
    endfunction

    function automatic logic [63:0] sqrt_floor(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // exp(-0.1*|v|) in Q0.32 from the product of exp(-2^k) terms
    function automatic logic [63:0] speed_decay(logic [63:0] v);
        logic [127:0] x;
        logic [127:0] acc;
        if (v >= (64'd160 << 16)) return 0;
        x   = ({64'd0, v} * 128'd429496730) >> 32;
        acc = 128'd1 << 32;
        for (int i = 0; i < rcf_pkg::EXP_TERMS; i++)
            if (x[i]) acc = (acc * rcf_pkg::EXP_TAB[i]) >> 32;
        return acc[63:0];
    endfunction

    // |v| / sqrt(v^2 + 0.01^2) in Q0.32, with |v| clipped to 16.0
    function automatic logic [63:0] speed_regulariser(logic [63:0] v);
        logic [63:0]  vc;
        logic [63:0]  q;
        logic [127:0] r;
        vc = (v > (64'd1 << 20)) ? (64'd1 << 20) : v;
        q  = sqrt_floor(((vc * vc) << 16) + 64'd28147497671);
        r  = ({64'd0, vc} << 40) / q;
        return (r > (128'd1 << 32)) ? (64'd1 << 32) : r[63:0];
    endfunction

    function automatic logic [17:0] friction_coeff_of(logic [63:0] slip_mag);
        logic [127:0] v;
        logic [63:0]  e;
        logic [63:0]  base;
        logic [127:0] mu;
        v = ({64'd0, slip_mag} << 32) / ((dt_q == 0) ? 128'd1 : {96'd0, dt_q});
        if (!en_q) return 0;
        e = speed_decay(v[63:0]);
        if (mus_q >= mud_q) base = 64'(mud_q + (((mus_q - mud_q) * {64'd0, e}) >> 32));
        else                base = 64'(mud_q - (((mud_q - mus_q) * {64'd0, e}) >> 32));
        mu = ({64'd0, base} * speed_regulariser(v[63:0])) >> 32;
        return mu[17:0];
    endfunction

    function automatic t_contact_res contact_forces(logic [31:0] gn, logic [31:0] gt,
                                                    logic [47:0] pn, logic [47:0] pt);
        t_contact_res res;
        logic [63:0]  nmag;
        logic [63:0]  tmag;
        logic [63:0]  fn_mag;
        logic [63:0]  ft_mag;
        logic [63:0]  lim;
        nmag   = gn[31] ? (64'h1_0000_0000 - gn) : {32'd0, gn};
        tmag   = gt[31] ? (64'h1_0000_0000 - gt) : {32'd0, gt};
        fn_mag = mul_q16_sat(nmag, pn, gn[31] ? rcf_pkg::NEG_CAP : rcf_pkg::POS_CAP);
        ft_mag = mul_q16_sat(tmag, pt, gt[31] ? rcf_pkg::NEG_CAP : rcf_pkg::POS_CAP);
        res.normal_force   = gn[31] ? -fn_mag : fn_mag;
        res.tangent_force  = gt[31] ? -ft_mag : ft_mag;
        res.friction_coeff = friction_coeff_of(tmag);
        lim = mul_q16_sat({46'd0, res.friction_coeff}, fn_mag, rcf_pkg::POS_CAP);
        res.slip = ft_mag > lim;
        // sign is dropped when sliding
        if (res.slip) res.tangent_force = lim;
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_results = 0;
        o_slips   = 0;
    end

    always @(posedge i_clk) begin
        t_contact_res want;
        if (!i_rst_n) begin
            en_q  <= 1'b0;
            mus_q <= '0;
            mud_q <= '0;
            dt_q  <= rcf_pkg::TIME_STEP_RST;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    rcf_pkg::CFG_FRICTION_ENABLE: en_q  <= i_cfg.data[0];
                    rcf_pkg::CFG_MU_STICK:        mus_q <= i_cfg.data[17:0];
                    rcf_pkg::CFG_MU_SLIDE:        mud_q <= i_cfg.data[17:0];
                    rcf_pkg::CFG_TIME_STEP:       dt_q  <= i_cfg.data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                forces_due.push_back(contact_forces(i_in.gap_normal, i_in.gap_tangent,
                                                    i_in.penalty_normal, i_in.penalty_tangent));
            if (i_out.valid && i_out.ready) begin
                if (forces_due.size() == 0) begin
                    $display("[%0t] result with nothing outstanding", $realtime);
                    o_errors++;
                end else begin
                    want = forces_due.pop_front();
                    o_results++;
                    if (want.slip) o_slips++;
                    if (i_out.normal_force !== want.normal_force)
                        report_mismatch("normal_force", i_out.normal_force, want.normal_force);
                    if (i_out.tangent_force !== want.tangent_force)
                        report_mismatch("tangent_force", i_out.tangent_force,
                                        want.tangent_force);
                    if (i_out.friction_coeff !== want.friction_coeff)
                        report_mismatch("friction_coeff", i_out.friction_coeff,
                                        want.friction_coeff);
                    if (i_out.slip !== want.slip)
                        report_mismatch("slip", i_out.slip, want.slip);
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the friction block testbench: clock, reset, contact point and register stimulus.
// Depends on rcf_pkg, the channel interfaces, the block and rcf_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          HOLD_CYCLES    = 300;
    localparam logic [7:0]  CFG_UNUSED_IDX = 8'd7;

    logic i_clk;
    logic i_rst_n;
    int   cycles;
    int   errors, pending, results, slips;
    int   sent;
    logic idle_on;
    logic stall_on;
    logic hold_start;
    int   hold_left;
    int   burst_left;

    rcf_in_if  in_ch();
    rcf_out_if out_ch();
    rcf_cfg_if cfg_ch();

    regularized_coulomb_friction u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    rcf_checker u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (in_ch),
        .i_out    (out_ch),
        .i_cfg    (cfg_ch),
        .o_errors (errors),
        .o_pending(pending),
        .o_results(results),
        .o_slips  (slips)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request
    initial begin
        hold_left  = 0;
        burst_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_start) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_on && $urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(1, 4) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= i_rst_n;
            end
        end
    end

    task automatic send_point(logic [31:0] gn, logic [31:0] gt, logic [47:0] pn,
                              logic [47:0] pt);
        in_ch.valid           <= 1'b1;
        in_ch.gap_normal      <= gn;
        in_ch.gap_tangent     <= gt;
        in_ch.penalty_normal  <= pn;
        in_ch.penalty_tangent <= pt;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Wait for every outstanding result, then let the pipe settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (rcf_pkg::NST + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_friction(logic en, logic [31:0] ms, logic [31:0] md, logic [31:0] dt);
        write_reg(rcf_pkg::CFG_FRICTION_ENABLE, {31'd0, en});
        write_reg(rcf_pkg::CFG_MU_STICK, ms);
        write_reg(rcf_pkg::CFG_MU_SLIDE, md);
        write_reg(rcf_pkg::CFG_TIME_STEP, dt);
    endtask

    function automatic logic [31:0] rand_gap(bit slow);
        logic [31:0] g;
        case ($urandom_range(0, 5))
            0:       g = $urandom();
            1:       g = $urandom_range(0, 60);
            2:       g = slow ? $urandom_range(0, 3000) : $urandom_range(0, 20000);
            3:       g = $urandom_range(0, 20000);
            4:       g = $urandom_range(0, 1 << 20);
            default: g = $urandom_range(0, 1 << 16);
        endcase
        return $urandom_range(0, 1) ? -g : g;
    endfunction

    function automatic logic [47:0] rand_penalty();
        case ($urandom_range(0, 3))
            0:       return 48'({$urandom(), $urandom()});
            1:       return 48'($urandom_range(0, 1 << 24));
            default: return 48'({$urandom_range(0, 65535), $urandom()} >> $urandom_range(0, 40));
        endcase
    endfunction

    task automatic random_points(int n, bit slow);
        repeat (n) send_point(rand_gap(0), rand_gap(slow), rand_penalty(), rand_penalty());
    endtask

    initial begin
        sent = 0;
        i_rst_n      <= 1'b0;
        idle_on      <= 1'b1;
        stall_on     <= 1'b1;
        hold_start   <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.gap_normal      <= '0;
        in_ch.gap_tangent     <= '0;
        in_ch.penalty_normal  <= '0;
        in_ch.penalty_tangent <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: friction off, so any nonzero trial force slides to zero
        send_point(32'd65536, 32'd100, 48'd65536, 48'd65536);
        send_point(32'd0, 32'd0, 48'd0, 48'd0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        random_points(40, 0);
        drain();

        // Directed extremes with friction on
        set_friction(1'b1, 32'd39322, 32'd26214, rcf_pkg::TIME_STEP_RST);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd1);
        send_point(32'hFFFF_FFFF, 32'd1, 48'd1, 48'hFFFF_FFFF_FFFF);
        send_point(32'd65536, 32'd0, 48'd65536, 48'd65536);
        send_point(32'd65536, 32'd10, 48'h0010_0000_0000, 48'd655360);
        send_point(32'hFFFF_0000, 32'hFFFF_FFF6, 48'h0010_0000_0000, 48'h0010_0000_0000);
        send_point(32'd327680, 32'd687, 48'd6553600, 48'd6553600);
        send_point(32'd327680, 32'hFFFF_FD51, 48'd6553600, 48'd655360000);
        send_point(32'd1000, 32'd20000, 48'h0000_FFFF_FFFF, 48'd0);
        send_point(32'd0, 32'd5000, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        random_points(100, 0);
        // Hold the result side off while requests keep coming, so the pipe fills
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        random_points(150, 0);
        drain();

        // Static below dynamic; unused register index and high data bits dropped
        write_reg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
        set_friction(1'b1, 32'hFFFC_4000, 32'd131072, 32'd42949673);
        random_points(60, 1);
        // Pause the sender until every result is back
        drain();
        random_points(60, 1);
        drain();

        // Extremes: largest coefficients and smallest step, then zero step
        set_friction(1'b1, 32'd262143, 32'd0, 32'd1);
        random_points(50, 1);
        drain();
        set_friction(1'b1, 32'd0, 32'd262143, 32'd0);
        random_points(40, 1);
        drain();

        // Longest step, no idling on either side
        set_friction(1'b1, 32'd65536, 32'd13107, 32'hFFFF_FFFF);
        idle_on  <= 1'b0;
        stall_on <= 1'b0;
        @(posedge i_clk);
        random_points(180, 0);
        drain();

        $display("%0d contact points sent, %0d results checked, %0d sliding", sent, results,
                 slips);
        $display("six register settings incl. friction off, extreme coefficients and steps");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
